// ===== hdl/ufr_pkg.sv =====
package ufr_pkg;

   localparam int DEPTH    = 16;
   localparam int HANDLE_W = 32;
   localparam int IDX_W    = $clog2(DEPTH);
   localparam int CNT_W    = $clog2(DEPTH + 1);
   localparam int OP_W     = 2;
   localparam int STAT_W   = 3;

   // operation codes
   localparam logic [OP_W-1:0] OP_PUSH   = 2'd0;
   localparam logic [OP_W-1:0] OP_POP    = 2'd1;
   localparam logic [OP_W-1:0] OP_REMOVE = 2'd2;
   localparam logic [OP_W-1:0] OP_QUERY  = 2'd3;

   // result status codes
   localparam logic [STAT_W-1:0] ST_DONE   = 3'd0;
   localparam logic [STAT_W-1:0] ST_DUP    = 3'd1;
   localparam logic [STAT_W-1:0] ST_FULL   = 3'd2;
   localparam logic [STAT_W-1:0] ST_EMPTY  = 3'd3;
   localparam logic [STAT_W-1:0] ST_ABSENT = 3'd4;

   // controller to datapath commands
   typedef struct packed {
      logic capture;
      logic lookup;
      logic exec;
      logic shift_step;
      logic load_rsp;
   } ufr_cmd_type;

   // datapath to controller status
   typedef struct packed {
      logic remove_hit;
      logic shift_done;
   } ufr_stat_type;

   // index plus count, wrapped around the ring
   function automatic logic [IDX_W-1:0] ring_add(input logic [IDX_W-1:0] idx,
                                                 input logic [CNT_W-1:0] n);
      logic [CNT_W:0] sum;
      sum = {{(CNT_W + 1 - IDX_W){1'b0}}, idx} + {1'b0, n};
      if (sum >= (CNT_W + 1)'(DEPTH)) begin
         sum = sum - (CNT_W + 1)'(DEPTH);
      end
      return sum[IDX_W-1:0];
   endfunction

   // distance of idx past base, wrapped around the ring
   function automatic logic [IDX_W-1:0] ring_offset(input logic [IDX_W-1:0] idx,
                                                    input logic [IDX_W-1:0] base);
      logic [IDX_W:0] diff;
      diff = {1'b0, idx} - {1'b0, base};
      if (diff[IDX_W]) begin
         diff = diff + (IDX_W + 1)'(DEPTH);
      end
      return diff[IDX_W-1:0];
   endfunction

endpackage

// ===== hdl/ufr_req_if.sv =====
interface ufr_req_if;
   import ufr_pkg::*;

   logic                valid;
   logic                ready;
   logic [OP_W-1:0]     operation;
   logic [HANDLE_W-1:0] handle_in;

   modport source (output valid, output operation, output handle_in, input ready);
   modport sink   (input valid, input operation, input handle_in, output ready);
endinterface

// ===== hdl/ufr_rsp_if.sv =====
interface ufr_rsp_if;
   import ufr_pkg::*;

   logic                valid;
   logic                ready;
   logic [HANDLE_W-1:0] handle_out;
   logic [STAT_W-1:0]   status;
   logic                found;
   logic [CNT_W-1:0]    occupancy;

   modport source (output valid, output handle_out, output status, output found,
                   output occupancy, input ready);
   modport sink   (input valid, input handle_out, input status, input found,
                   input occupancy, output ready);
endinterface

// ===== hdl/ufr_datapath.sv =====
module ufr_datapath
   import ufr_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  ufr_cmd_type         cmd,
   output ufr_stat_type        stat,
   input  logic [OP_W-1:0]     req_operation,
   input  logic [HANDLE_W-1:0] req_handle_in,
   output logic [HANDLE_W-1:0] rsp_handle_out,
   output logic [STAT_W-1:0]   rsp_status,
   output logic                rsp_found,
   output logic [CNT_W-1:0]    rsp_occupancy
);

   logic [HANDLE_W-1:0] slot_mem [DEPTH];

   logic [IDX_W-1:0]    oldest_ff, oldest_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic [OP_W-1:0]     op_ff;
   logic [HANDLE_W-1:0] handle_ff;
   logic                hit_ff, hit_in;
   logic [IDX_W-1:0]    match_ff, match_in;
   logic [IDX_W-1:0]    cursor_ff, cursor_in;
   logic [CNT_W-1:0]    left_ff, left_in;
   logic [HANDLE_W-1:0] res_handle_ff, res_handle_in;
   logic [STAT_W-1:0]   res_status_ff, res_status_in;
   logic                res_found_ff, res_found_in;
   logic [HANDLE_W-1:0] rsp_handle_ff;
   logic [STAT_W-1:0]   rsp_status_ff;
   logic                rsp_found_ff;
   logic [CNT_W-1:0]    rsp_count_ff;

   logic [IDX_W-1:0]    wr_idx;
   logic [HANDLE_W-1:0] wr_data;
   logic                wr_en;
   logic [IDX_W-1:0]    rd_addr;
   logic [HANDLE_W-1:0] rd_data;
   logic [DEPTH-1:0]    match_vec;

   // compare the handle against every held entry
   always_comb begin
      for (int i = 0; i < DEPTH; i++) begin
         match_vec[i] = ({1'b0, ring_offset(IDX_W'(i), oldest_ff)} < count_ff)
                        && (slot_mem[i] == handle_ff);
      end
   end

   // encode the matching slot (handles are unique, so at most one)
   always_comb begin
      hit_in   = |match_vec;
      match_in = '0;
      for (int i = 0; i < DEPTH; i++) begin
         if (match_vec[i]) begin
            match_in = IDX_W'(i);
         end
      end
   end

   // one read port: oldest for pop, the entry after the cursor for a shift
   assign rd_addr = cmd.exec ? oldest_ff : ring_add(cursor_ff, CNT_W'(1));
   assign rd_data = slot_mem[rd_addr];

   // execute the operation and step the remove compaction
   always_comb begin
      oldest_in     = oldest_ff;
      count_in      = count_ff;
      cursor_in     = cursor_ff;
      left_in       = left_ff;
      res_handle_in = res_handle_ff;
      res_status_in = res_status_ff;
      res_found_in  = res_found_ff;
      wr_en         = 1'b0;
      wr_idx        = ring_add(oldest_ff, count_ff);
      wr_data       = handle_ff;
      if (cmd.exec) begin
         res_handle_in = '0;
         res_status_in = ST_DONE;
         res_found_in  = hit_ff;
         cursor_in     = match_ff;
         left_in       = count_ff - CNT_W'(1)
                         - {{(CNT_W - IDX_W){1'b0}}, ring_offset(match_ff, oldest_ff)};
         case (op_ff)
            OP_PUSH: begin
               if (hit_ff) begin
                  res_status_in = ST_DUP;
               end else if (count_ff == CNT_W'(DEPTH)) begin
                  res_status_in = ST_FULL;
               end else begin
                  wr_en    = 1'b1;
                  count_in = count_ff + CNT_W'(1);
               end
            end
            OP_POP: begin
               res_found_in = 1'b0;
               if (count_ff == '0) begin
                  res_status_in = ST_EMPTY;
               end else begin
                  res_handle_in = rd_data;
                  oldest_in     = ring_add(oldest_ff, CNT_W'(1));
                  count_in      = count_ff - CNT_W'(1);
               end
            end
            OP_REMOVE: begin
               if (!hit_ff) begin
                  res_status_in = ST_ABSENT;
               end
            end
            OP_QUERY: begin
               res_status_in = ST_DONE;
            end
            default: begin
               res_status_in = ST_DONE;
            end
         endcase
      end else if (cmd.shift_step) begin
         if (left_ff == '0) begin
            count_in = count_ff - CNT_W'(1);
         end else begin
            wr_en     = 1'b1;
            wr_idx    = cursor_ff;
            wr_data   = rd_data;
            cursor_in = ring_add(cursor_ff, CNT_W'(1));
            left_in   = left_ff - CNT_W'(1);
         end
      end
   end

   // write the handle store
   always_ff @(posedge clock) begin
      if (wr_en) begin
         slot_mem[wr_idx] <= wr_data;
      end
   end

   // hold ring pointers
   always_ff @(posedge clock) begin
      if (reset) begin
         oldest_ff <= '0;
         count_ff  <= '0;
      end else begin
         oldest_ff <= oldest_in;
         count_ff  <= count_in;
      end
   end

   // capture the word, lookup result and work registers
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff     <= req_operation;
         handle_ff <= req_handle_in;
      end
      if (cmd.lookup) begin
         hit_ff   <= hit_in;
         match_ff <= match_in;
      end
      cursor_ff     <= cursor_in;
      left_ff       <= left_in;
      res_handle_ff <= res_handle_in;
      res_status_ff <= res_status_in;
      res_found_ff  <= res_found_in;
      if (cmd.load_rsp) begin
         rsp_handle_ff <= res_handle_ff;
         rsp_status_ff <= res_status_ff;
         rsp_found_ff  <= res_found_ff;
         rsp_count_ff  <= count_ff;
      end
   end

   assign stat.remove_hit = (op_ff == OP_REMOVE) && hit_ff;
   assign stat.shift_done = (left_ff == '0);

   assign rsp_handle_out = rsp_handle_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_found      = rsp_found_ff;
   assign rsp_occupancy  = rsp_count_ff;

endmodule

// ===== hdl/ufr_control.sv =====
module ufr_control
   import ufr_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output ufr_cmd_type  cmd,
   input  ufr_stat_type stat
);

   typedef enum logic [4:0] {
      S_IDLE   = 5'b00001,
      S_LOOKUP = 5'b00010,
      S_EXEC   = 5'b00100,
      S_SHIFT  = 5'b01000,
      S_FINISH = 5'b10000
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      load;

   assign req_ready = (state_ff == S_IDLE);
   assign load      = (state_ff == S_FINISH) && (!rsp_valid_ff || rsp_ready);

   // sequence one word through lookup, execute, compaction and hand-off
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               state_in = S_LOOKUP;
            end
         end
         S_LOOKUP: begin
            state_in = S_EXEC;
         end
         S_EXEC: begin
            state_in = stat.remove_hit ? S_SHIFT : S_FINISH;
         end
         S_SHIFT: begin
            if (stat.shift_done) begin
               state_in = S_FINISH;
            end
         end
         S_FINISH: begin
            if (load) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // drive datapath commands
   always_comb begin
      cmd.capture    = (state_ff == S_IDLE) && req_valid;
      cmd.lookup     = (state_ff == S_LOOKUP);
      cmd.exec       = (state_ff == S_EXEC);
      cmd.shift_step = (state_ff == S_SHIFT);
      cmd.load_rsp   = load;
   end

   // hold the output word until taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

// ===== hdl/unique_fifo_with_remove.sv =====
// Channel   Dir  Fields                                    Handshake
// req_chan  in   operation[1:0], handle_in[31:0]           valid/ready
// rsp_chan  out  handle_out[31:0], status[2:0], found,     valid/ready
//                occupancy[4:0]
//
// Push, pop, query and a remove that misses go from accept through the lookup,
// execute and finish states, loading the output register in finish; the next
// word is taken only back in idle. Remove of a held handle also passes through
// the shift state, where the compaction shifts each entry queued behind it, one
// entry per cycle, through the single store read port.
// Reset clears the ring pointers and count; the handle store is not cleared.
// A finished word waits in the output register while the next word is taken;
// the next one then stalls in its last cycle until the output word is taken.
module unique_fifo_with_remove
   import ufr_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   ufr_req_if.sink   req_chan,
   ufr_rsp_if.source rsp_chan
);

   ufr_cmd_type  cmd;
   ufr_stat_type stat;

   ufr_control u_control (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .cmd       (cmd),
      .stat      (stat)
   );

   ufr_datapath u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .stat           (stat),
      .req_operation  (req_chan.operation),
      .req_handle_in  (req_chan.handle_in),
      .rsp_handle_out (rsp_chan.handle_out),
      .rsp_status     (rsp_chan.status),
      .rsp_found      (rsp_chan.found),
      .rsp_occupancy  (rsp_chan.occupancy)
   );

endmodule

// ===== sim/tb_top.sv =====
module tb_top;
   import ufr_pkg::*;

   localparam int STALL_LIMIT = 2000;
   localparam int POOL_SIZE   = 20;
   localparam int PHASE_ITEMS = 370;

   // one result word, field by field
   typedef struct {
      logic [HANDLE_W-1:0] handle_out;
      logic [STAT_W-1:0]   status;
      logic                found;
      logic [CNT_W-1:0]    occupancy;
   } fifo_result_type;

   // Order-keeping view of the ring: a compacting remove keeps the survivors
   // in order, so a plain queue of handles (oldest first) predicts every field.
   class fifo_scoreboard_type;
      logic [HANDLE_W-1:0] queued_handles[$];
      fifo_result_type     pending_results[$];
      int                  mismatches;
      int                  checked;

      function void note_request(input logic [OP_W-1:0] op, input logic [HANDLE_W-1:0] h);
         fifo_result_type res;
         int              hits[$];
         hits           = queued_handles.find_first_index(x) with (x == h);
         res.handle_out = '0;
         res.status     = ST_DONE;
         res.found      = 1'b0;
         case (op)
            OP_PUSH: begin
               res.found = (hits.size() != 0);
               if (res.found) begin
                  res.status = ST_DUP;
               end else if (queued_handles.size() >= DEPTH) begin
                  res.status = ST_FULL;
               end else begin
                  queued_handles.push_back(h);
               end
            end
            OP_POP: begin
               // handle_in plays no part, so found stays low
               if (queued_handles.size() == 0) begin
                  res.status = ST_EMPTY;
               end else begin
                  res.handle_out = queued_handles.pop_front();
               end
            end
            OP_REMOVE: begin
               res.found = (hits.size() != 0);
               if (res.found) begin
                  queued_handles.delete(hits[0]);
               end else begin
                  res.status = ST_ABSENT;
               end
            end
            default: begin
               res.found = (hits.size() != 0);
            end
         endcase
         res.occupancy = CNT_W'(queued_handles.size());
         pending_results.push_back(res);
      endfunction

      task report_mismatch(input string what);
         $display("[%0t] result %0d: %s", $time, checked, what);
         mismatches++;
      endtask

      task check_result(input fifo_result_type got);
         fifo_result_type want;
         checked++;
         if (pending_results.size() == 0) begin
            report_mismatch($sformatf("unexpected word, handle_out %08h status %0d",
                                      got.handle_out, got.status));
         end else begin
            want = pending_results.pop_front();
            if (got.handle_out !== want.handle_out)
               report_mismatch($sformatf("handle_out %08h, expected %08h",
                                         got.handle_out, want.handle_out));
            if (got.status !== want.status)
               report_mismatch($sformatf("status %0d, expected %0d", got.status, want.status));
            if (got.found !== want.found)
               report_mismatch($sformatf("found %0b, expected %0b", got.found, want.found));
            if (got.occupancy !== want.occupancy)
               report_mismatch($sformatf("occupancy %0d, expected %0d",
                                         got.occupancy, want.occupancy));
         end
      endtask
   endclass

   logic clock;
   logic reset;

   ufr_req_if req_chan ();
   ufr_rsp_if rsp_chan ();

   unique_fifo_with_remove i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   fifo_scoreboard_type sb = new();
   logic [HANDLE_W-1:0] pool[POOL_SIZE];
   int                  send_idle_pct;
   int                  recv_idle_pct;
   bit                  calm;
   int                  stall_cycles = 0;

   // clock
   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // note every accepted request word
   always @(posedge clock) begin
      if (!reset && req_chan.valid && req_chan.ready)
         sb.note_request(req_chan.operation, req_chan.handle_in);
   end

   // check every accepted result word
   always @(posedge clock) begin
      if (!reset && rsp_chan.valid && rsp_chan.ready)
         sb.check_result('{rsp_chan.handle_out, rsp_chan.status, rsp_chan.found,
                           rsp_chan.occupancy});
   end

   // stall the result channel at random
   always @(posedge clock) begin
      rsp_chan.ready <= calm || ($urandom_range(99) >= recv_idle_pct);
   end

   // end the run when nothing moves for too long
   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready))
         stall_cycles <= 0;
      else
         stall_cycles <= stall_cycles + 1;
      if (stall_cycles == STALL_LIMIT) begin
         $display("unique_fifo_with_remove regression: fail");
         $finish;
      end
   end

   // offer one word, after an optional gap, and hold it until taken
   task automatic send_word(input logic [OP_W-1:0] op, input logic [HANDLE_W-1:0] h);
      if (!calm && $urandom_range(99) < send_idle_pct) begin
         req_chan.valid <= 1'b0;
         do @(posedge clock); while (!calm && $urandom_range(99) < send_idle_pct);
      end
      req_chan.valid     <= 1'b1;
      req_chan.operation <= op;
      req_chan.handle_in <= h;
      do @(posedge clock); while (!req_chan.ready);
   endtask

   // drop valid and hold until every expected word has come back
   task automatic wait_for_results();
      req_chan.valid <= 1'b0;
      do @(posedge clock); while (sb.pending_results.size() != 0);
   endtask

   // mostly handles already queued or from a small pool, so hits are common
   function automatic logic [HANDLE_W-1:0] pick_handle(input logic [OP_W-1:0] op);
      int roll;
      roll = $urandom_range(99);
      if (op != OP_PUSH && op != OP_POP && roll < 50 && sb.queued_handles.size() != 0)
         return sb.queued_handles[$urandom_range(sb.queued_handles.size() - 1)];
      if (op != OP_POP && roll < 85)
         return pool[$urandom_range(POOL_SIZE - 1)];
      return $urandom();
   endfunction

   task automatic run_directed();
      // empty ring: pop, remove and query all miss
      send_word(OP_POP, 32'h0);
      send_word(OP_REMOVE, '1);
      send_word(OP_QUERY, 32'h0);
      // zero is an ordinary handle; the second push is a duplicate
      send_word(OP_PUSH, 32'h0);
      send_word(OP_PUSH, 32'h0);
      send_word(OP_PUSH, '1);
      send_word(OP_QUERY, '1);
      send_word(OP_QUERY, 32'h0000_0001);
      // remove the oldest, then pop with a junk handle
      send_word(OP_REMOVE, 32'h0);
      send_word(OP_POP, 32'hA5A5_5A5A);
      // fill the ring, push into it while full, then remove from the middle and the end
      for (int i = 0; i < DEPTH; i++)
         send_word(OP_PUSH, 32'h8000_0001 ^ (i * 32'h0101_0101));
      send_word(OP_PUSH, 32'h1234_5678);
      send_word(OP_PUSH, 32'h8000_0001);
      send_word(OP_REMOVE, 32'h8000_0001 ^ (7 * 32'h0101_0101));
      send_word(OP_REMOVE, 32'h8000_0001 ^ ((DEPTH - 1) * 32'h0101_0101));
      send_word(OP_POP, 32'h0);
   endtask

   task automatic run_phase(input int items, input int s_pct, input int r_pct);
      logic [OP_W-1:0] op;
      int              roll;
      bit              filling;
      send_idle_pct = s_pct;
      recv_idle_pct = r_pct;
      foreach (pool[i]) pool[i] = $urandom();
      for (int n = 0; n < items; n++) begin
         // switch at random between filling and draining stretches, some with no idling
         if (n % 32 == 0) begin
            filling = $urandom_range(1);
            calm    = ($urandom_range(3) == 0);
         end
         if ($urandom_range(79) == 0)
            wait_for_results();
         roll = $urandom_range(99);
         if (roll < (filling ? 60 : 25))
            op = OP_PUSH;
         else if (roll < (filling ? 75 : 55))
            op = OP_POP;
         else if (roll < (filling ? 90 : 80))
            op = OP_REMOVE;
         else
            op = OP_QUERY;
         send_word(op, pick_handle(op));
      end
      calm = 1'b0;
   endtask

   // main sequence
   initial begin
      reset              <= 1'b1;
      req_chan.valid     <= 1'b0;
      req_chan.operation <= OP_PUSH;
      req_chan.handle_in <= '0;
      send_idle_pct = 36;
      recv_idle_pct = 69;
      calm          = 1'b0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      run_directed();
      run_phase(PHASE_ITEMS, 36, 69);
      wait_for_results();
      run_phase(PHASE_ITEMS, 69, 36);
      wait_for_results();
      run_phase(PHASE_ITEMS, 0, 0);
      wait_for_results();
      repeat (40) @(posedge clock);

      if (sb.mismatches == 0 && sb.pending_results.size() == 0)
         $display("unique_fifo_with_remove regression: pass");
      else
         $display("unique_fifo_with_remove regression: fail");
      $finish;
   end

endmodule

// ===== files.f =====
hdl/ufr_pkg.sv
hdl/ufr_req_if.sv
hdl/ufr_rsp_if.sv
hdl/ufr_datapath.sv
hdl/ufr_control.sv
hdl/unique_fifo_with_remove.sv
sim/tb_top.sv
